// File: design/vtsrs_pkg.sv
// ----------------------------------------------------------------------------
// vtsrs_pkg: shared types and codes of the value table unit.
// Request modes, result status codes and sequencer state encoding.
// ----------------------------------------------------------------------------
package vtsrs_pkg;

	typedef enum logic [2:0] {
		MODE_APPEND     = 3'd0,
		MODE_SEARCH     = 3'd1,
		MODE_REMOVE_ONE = 3'd2,
		MODE_REMOVE_ALL = 3'd3,
		MODE_LIST       = 3'd4,
		MODE_SORT_UP    = 3'd5,
		MODE_SORT_DOWN  = 3'd6,
		MODE_NONE       = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_FULL     = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_MATCH    = 3'd3,
		ST_ELEMENT  = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SCAN  = 9'b000000010,
		S_COPY  = 9'b000000100,
		S_CMP   = 9'b000001000,
		S_EMIT  = 9'b000010000,
		S_COMP  = 9'b000100000,
		S_SRCH  = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_WAIT  = 9'b100000000
	} state_t;

endpackage

// File: design/vtsrs_ram.sv
// ----------------------------------------------------------------------------
// vtsrs_ram: generic single-port-write, single-read RAM.
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vtsrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/value_table_search_remove_sort_unit.sv
// ----------------------------------------------------------------------------
// value_table_search_remove_sort_unit: ordered value table with search,
// removal, listing and sorted listing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the last result has been presented. Results appear one per strobe
// cycle and the receiver cannot stall them. All work goes through one table
// RAM and one scratch RAM with registered reads and a single comparator. A
// search scans the stored entries in two passes, a remove compacts them in
// one pass and a list reads them once. A sort copies the table into the
// scratch RAM, runs compare-exchange passes there and then outputs the
// sorted entries. An append writes the table directly from the idle state.
// ----------------------------------------------------------------------------
module value_table_search_remove_sort_unit #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic signed [31:0] operand_value,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [5:0]  position,
	output logic signed [31:0] element_value,
	output logic [5:0]  entry_count,
	output logic        last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	vtsrs_pkg::state_t state_q;
	vtsrs_pkg::mode_t  mode_q;
	logic [31:0]       val_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     i_q;      // read index
	logic [CW-1:0]     w_q;      // write index for compaction
	logic [CW-1:0]     k_q;      // outer sort index
	logic [CW-1:0]     lastpos_q;
	logic              found_q;
	logic              done_one_q;
	logic [1:0]        ph_q;     // sort sub-phase
	logic [31:0]       a_q;

	// RAM ports.
	logic            t_we, s_we;
	logic [AW-1:0]   t_wa, t_ra, s_wa, s_ra;
	logic [31:0]     t_wd, t_rd, s_wd, s_rd;

	vtsrs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
	vtsrs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_scratch (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	// Shared compare unit.
	logic        eq;
	logic        gt;
	logic [31:0] cmp_a, cmp_b;
	always_comb begin
		cmp_a = t_rd;
		cmp_b = val_q;
		if (state_q == vtsrs_pkg::S_CMP) begin
			cmp_a = a_q;
			cmp_b = s_rd;
		end
	end
	assign eq = (cmp_a == cmp_b);
	assign gt = ((cmp_a ^ 32'h8000_0000) > (cmp_b ^ 32'h8000_0000));

	logic exch;
	assign exch = (mode_q == vtsrs_pkg::MODE_SORT_DOWN) ? (!gt && !eq) : gt;

	// Registered read valid: the item at i_q-1 is on t_rd / s_rd.
	logic [CW-1:0] ip;
	assign ip = i_q - CW'(1);

	assign busy = (state_q != vtsrs_pkg::S_IDLE);

	// RAM addressing.
	always_comb begin
		t_we = 1'b0;
		t_wa = w_q[AW-1:0];
		t_wd = t_rd;
		t_ra = i_q[AW-1:0];
		s_we = 1'b0;
		s_wa = ip[AW-1:0];
		s_wd = t_rd;
		s_ra = i_q[AW-1:0];
		unique case (state_q)
			vtsrs_pkg::S_IDLE: begin
				t_we = start && (mode == vtsrs_pkg::MODE_APPEND) && (cnt_q < CW'(DEPTH));
				t_wa = cnt_q[AW-1:0];
				t_wd = operand_value;
				t_ra = '0;
			end
			vtsrs_pkg::S_COMP: begin
				t_we = (i_q != '0) && (ip < cnt_q) && !(eq && !done_one_q);
				t_wa = w_q[AW-1:0];
			end
			vtsrs_pkg::S_COPY: begin
				s_we = (i_q != '0);
				s_wa = ip[AW-1:0];
			end
			vtsrs_pkg::S_CMP: begin
				s_ra = (ph_q == 2'd0) ? k_q[AW-1:0] : i_q[AW-1:0];
				s_we = (ph_q == 2'd2) && exch;
				s_wa = i_q[AW-1:0];
				s_wd = a_q;
			end
			vtsrs_pkg::S_EMIT: begin
				s_ra = i_q[AW-1:0];
			end
			default: ;
		endcase
		if (state_q == vtsrs_pkg::S_CMP && ph_q == 2'd3) begin
			s_we = 1'b1;
			s_wa = k_q[AW-1:0];
			s_wd = a_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= vtsrs_pkg::S_IDLE;
			cnt_q         <= '0;
			strobe        <= 1'b0;
			mode_q        <= vtsrs_pkg::MODE_APPEND;
			val_q         <= '0;
			a_q           <= '0;
			i_q           <= '0;
			w_q           <= '0;
			k_q           <= '0;
			ph_q          <= '0;
			found_q       <= 1'b0;
			done_one_q    <= 1'b0;
			lastpos_q     <= '0;
			status        <= '0;
			position      <= '0;
			element_value <= '0;
			entry_count   <= '0;
			last          <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				vtsrs_pkg::S_IDLE: begin
					if (start) begin
						mode_q     <= vtsrs_pkg::mode_t'(mode);
						val_q      <= operand_value;
						i_q        <= '0;
						w_q        <= '0;
						found_q    <= 1'b0;
						done_one_q <= 1'b0;
						position      <= '0;
						element_value <= '0;
						last          <= 1'b1;
						unique case (mode)
							vtsrs_pkg::MODE_APPEND: begin
								state_q <= vtsrs_pkg::S_WAIT;
								strobe  <= 1'b1;
								if (cnt_q < CW'(DEPTH)) begin
									status      <= vtsrs_pkg::ST_DONE;
									entry_count <= 6'(cnt_q + CW'(1));
									cnt_q       <= cnt_q + CW'(1);
								end else begin
									status      <= vtsrs_pkg::ST_FULL;
									entry_count <= 6'(cnt_q);
								end
							end
							vtsrs_pkg::MODE_SEARCH: state_q <= vtsrs_pkg::S_SCAN;
							vtsrs_pkg::MODE_REMOVE_ONE,
							vtsrs_pkg::MODE_REMOVE_ALL: state_q <= vtsrs_pkg::S_COMP;
							vtsrs_pkg::MODE_LIST,
							vtsrs_pkg::MODE_SORT_UP,
							vtsrs_pkg::MODE_SORT_DOWN: begin
								if (cnt_q == '0) begin
									state_q     <= vtsrs_pkg::S_WAIT;
									strobe      <= 1'b1;
									status      <= vtsrs_pkg::ST_EMPTY;
									entry_count <= '0;
								end else if (mode == vtsrs_pkg::MODE_LIST) begin
									state_q <= vtsrs_pkg::S_EMIT;
								end else begin
									state_q <= vtsrs_pkg::S_COPY;
								end
							end
							default: begin
								state_q     <= vtsrs_pkg::S_WAIT;
								strobe      <= 1'b1;
								status      <= vtsrs_pkg::ST_DONE;
								entry_count <= 6'(cnt_q);
							end
						endcase
					end
				end
				// Search pass one: find the last matching position.
				vtsrs_pkg::S_SCAN: begin
					if (i_q != '0 && eq) begin
						found_q   <= 1'b1;
						lastpos_q <= ip;
					end
					if (i_q == cnt_q) begin
						state_q <= vtsrs_pkg::S_SRCH;
						i_q     <= '0;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				// Search pass two: report each match.
				vtsrs_pkg::S_SRCH: begin
					if (!found_q) begin
						state_q     <= vtsrs_pkg::S_WAIT;
						strobe      <= 1'b1;
						status      <= vtsrs_pkg::ST_NOTFOUND;
						entry_count <= 6'(cnt_q);
						last        <= 1'b1;
					end else begin
						if (i_q != '0 && eq) begin
							strobe      <= 1'b1;
							status      <= vtsrs_pkg::ST_MATCH;
							position    <= 6'(i_q);
							entry_count <= 6'(cnt_q);
							last        <= (ip == lastpos_q);
						end
						if (i_q != '0 && ip == lastpos_q) begin
							state_q <= vtsrs_pkg::S_WAIT;
						end else begin
							i_q <= i_q + CW'(1);
						end
					end
				end
				// Compaction for both remove modes.
				vtsrs_pkg::S_COMP: begin
					if (i_q != '0 && ip < cnt_q) begin
						if (eq && !done_one_q) begin
							found_q <= 1'b1;
							if (mode_q == vtsrs_pkg::MODE_REMOVE_ONE) begin
								done_one_q <= 1'b1;
							end
						end else begin
							w_q <= w_q + CW'(1);
						end
					end
					if (i_q == cnt_q) begin
						state_q <= vtsrs_pkg::S_FIN;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				vtsrs_pkg::S_FIN: begin
					state_q     <= vtsrs_pkg::S_WAIT;
					strobe      <= 1'b1;
					last        <= 1'b1;
					status      <= found_q ? vtsrs_pkg::ST_DONE : vtsrs_pkg::ST_NOTFOUND;
					cnt_q       <= w_q;
					entry_count <= 6'(w_q);
				end
				// Copy table into scratch.
				vtsrs_pkg::S_COPY: begin
					if (i_q == cnt_q) begin
						state_q <= vtsrs_pkg::S_CMP;
						k_q     <= '0;
						i_q     <= CW'(1);
						ph_q    <= 2'd0;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				// Exchange sort: ph 0 read k, 1 latch a, 2 compare/swap i, 3 write k.
				vtsrs_pkg::S_CMP: begin
					unique case (ph_q)
						2'd0: begin
							if (k_q + CW'(1) >= cnt_q) begin
								state_q <= vtsrs_pkg::S_EMIT;
								i_q     <= '0;
							end else begin
								ph_q <= 2'd1;
							end
						end
						2'd1: begin
							// Only the first pair of an outer pass loads a_q; later it is current.
							if (i_q == k_q + CW'(1)) begin
								a_q <= s_rd;
							end
							ph_q <= 2'd2;
						end
						2'd2: begin
							if (exch) begin
								a_q <= s_rd;
							end
							if (i_q + CW'(1) >= cnt_q) begin
								ph_q <= 2'd3;
							end else begin
								i_q  <= i_q + CW'(1);
								ph_q <= 2'd1;
							end
						end
						default: begin
							k_q  <= k_q + CW'(1);
							i_q  <= k_q + CW'(2);
							ph_q <= 2'd0;
						end
					endcase
				end
				// Emit elements from table (list) or scratch (sorts).
				vtsrs_pkg::S_EMIT: begin
					if (i_q != '0) begin
						strobe        <= 1'b1;
						status        <= vtsrs_pkg::ST_ELEMENT;
						position      <= 6'(i_q);
						element_value <= (mode_q == vtsrs_pkg::MODE_LIST) ? t_rd : s_rd;
						entry_count   <= 6'(cnt_q);
						last          <= (i_q == cnt_q);
					end
					if (i_q == cnt_q) begin
						state_q <= vtsrs_pkg::S_WAIT;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				vtsrs_pkg::S_WAIT: begin
					state_q <= vtsrs_pkg::S_IDLE;
				end
				default: state_q <= vtsrs_pkg::S_IDLE;
			endcase
		end
	end

endmodule

// File: test/value_table_search_remove_sort_unit_test.sv
// ----------------------------------------------------------------------------
// value_table_search_remove_sort_unit_test: self-checking bench of the table unit.
// Requests are driven with random gaps. A behavioral table model predicts every
// result, and a monitor compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module value_table_search_remove_sort_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH     = 32;
	localparam int MAX_CYCLE = 3000000;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  position;
		logic [31:0] element_value;
		logic [5:0]  entry_count;
		logic        last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  mode = vtsrs_pkg::MODE_APPEND;
	logic signed [31:0] operand_value = '0;
	logic        strobe;
	logic [2:0]  status;
	logic [5:0]  position;
	logic signed [31:0] element_value;
	logic [5:0]  entry_count;
	logic        last;

	request_t    pending_requests[$];
	result_t     expected_results[$];
	logic [31:0] model_table[DEPTH];
	int          model_count = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          quiet_stretch = 1'b0;

	value_table_search_remove_sort_unit #(.DEPTH(DEPTH)) u_top (.*);

	always #4 clk = ~clk;

	// Queues one result of the current request.
	function automatic void push_result(logic [2:0] st, int pos, logic [31:0] val, bit fin);
		result_t r;
		r = '{st, pos[5:0], val, model_count[5:0], fin};
		expected_results.push_back(r);
	endfunction

	function automatic void delete_entry(int p);
		for (int k = p; k + 1 < model_count; k++)
			model_table[k] = model_table[k + 1];
		model_count--;
	endfunction

	// Applies one request to the table model and queues its results.
	function automatic void predict_table(request_t rq);
		logic [31:0] sorted[DEPTH];
		logic [31:0] t;
		int hits;
		int lastpos;
		bit found;
		int j;
		hits = 0;
		lastpos = 0;
		found = 0;
		j = 0;
		case (rq.mode)
			vtsrs_pkg::MODE_APPEND: begin
				if (model_count >= DEPTH) begin
					push_result(vtsrs_pkg::ST_FULL, 0, 0, 1);
				end else begin
					model_table[model_count] = rq.value;
					model_count++;
					push_result(vtsrs_pkg::ST_DONE, 0, 0, 1);
				end
			end
			vtsrs_pkg::MODE_SEARCH: begin
				for (int k = 0; k < model_count; k++)
					if (model_table[k] == rq.value) lastpos = k;
				for (int k = 0; k < model_count; k++)
					if (model_table[k] == rq.value) begin
						push_result(vtsrs_pkg::ST_MATCH, k + 1, 0, k == lastpos);
						hits++;
					end
				if (hits == 0) push_result(vtsrs_pkg::ST_NOTFOUND, 0, 0, 1);
			end
			vtsrs_pkg::MODE_REMOVE_ONE: begin
				for (int k = 0; k < model_count && !found; k++)
					if (model_table[k] == rq.value) begin
						delete_entry(k);
						found = 1;
					end
				push_result(found ? vtsrs_pkg::ST_DONE : vtsrs_pkg::ST_NOTFOUND, 0, 0, 1);
			end
			vtsrs_pkg::MODE_REMOVE_ALL: begin
				while (j < model_count) begin
					if (model_table[j] == rq.value) begin
						delete_entry(j);
						found = 1;
					end else begin
						j++;
					end
				end
				push_result(found ? vtsrs_pkg::ST_DONE : vtsrs_pkg::ST_NOTFOUND, 0, 0, 1);
			end
			vtsrs_pkg::MODE_LIST, vtsrs_pkg::MODE_SORT_UP, vtsrs_pkg::MODE_SORT_DOWN: begin
				if (model_count == 0) begin
					push_result(vtsrs_pkg::ST_EMPTY, 0, 0, 1);
				end else begin
					for (int k = 0; k < model_count; k++) sorted[k] = model_table[k];
					// Sorting is a plain signed ordering; the listing keeps stored order.
					if (rq.mode != vtsrs_pkg::MODE_LIST)
						for (int a = 0; a < model_count; a++)
							for (int b = a + 1; b < model_count; b++)
								if ((rq.mode == vtsrs_pkg::MODE_SORT_UP)
										? ($signed(sorted[a]) > $signed(sorted[b]))
										: ($signed(sorted[a]) < $signed(sorted[b]))) begin
									t = sorted[a];
									sorted[a] = sorted[b];
									sorted[b] = t;
								end
					for (int k = 0; k < model_count; k++)
						push_result(vtsrs_pkg::ST_ELEMENT, k + 1, sorted[k],
							k + 1 == model_count);
				end
			end
			default: push_result(vtsrs_pkg::ST_DONE, 0, 0, 1);
		endcase
	endfunction

	function automatic void add_request(logic [2:0] m, logic [31:0] v);
		pending_requests.push_back('{m, v});
	endfunction

	// Values come from a small pool most of the time so that matches are common.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			default: return $urandom_range(0, 7) - 3;
		endcase
	endfunction

	// Request driver: a request is taken on an edge where start is high and busy low.
	always @(posedge clk) begin
		bit taken;
		bit go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) predict_table('{mode, operand_value});
			if (!start || taken) begin
				go = (pending_requests.size() > 0)
					&& (quiet_stretch || $urandom_range(0, 99) >= 31);
				if (go) begin
					request_t rq;
					rq = pending_requests.pop_front();
					start <= 1'b1;
					mode <= rq.mode;
					operand_value <= rq.value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		if (arst_n && strobe) begin
			seen = '{status, position, element_value, entry_count, last};
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result %p", seen);
			end else begin
				want = expected_results.pop_front();
				if (seen !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p actual %p", want, seen);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLE) begin
			$display("timeout");
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		// Directed: empty table cases, every mode, fill to full and overflow.
		add_request(vtsrs_pkg::MODE_LIST, 0);
		add_request(vtsrs_pkg::MODE_SORT_UP, 0);
		add_request(vtsrs_pkg::MODE_SORT_DOWN, 0);
		add_request(vtsrs_pkg::MODE_SEARCH, 5);
		add_request(vtsrs_pkg::MODE_REMOVE_ONE, 5);
		add_request(vtsrs_pkg::MODE_REMOVE_ALL, 5);
		add_request(vtsrs_pkg::MODE_NONE, 32'hffff_ffff);
		add_request(vtsrs_pkg::MODE_APPEND, 32'h8000_0000);
		add_request(vtsrs_pkg::MODE_APPEND, 32'h7fff_ffff);
		add_request(vtsrs_pkg::MODE_APPEND, 0);
		add_request(vtsrs_pkg::MODE_APPEND, 32'h7fff_ffff);
		add_request(vtsrs_pkg::MODE_SEARCH, 32'h7fff_ffff);
		add_request(vtsrs_pkg::MODE_SORT_UP, 0);
		add_request(vtsrs_pkg::MODE_SORT_DOWN, 0);
		add_request(vtsrs_pkg::MODE_REMOVE_ONE, 32'h7fff_ffff);
		add_request(vtsrs_pkg::MODE_LIST, 0);
		add_request(vtsrs_pkg::MODE_REMOVE_ALL, 32'h8000_0000);
		for (int k = 0; k < DEPTH; k++) add_request(vtsrs_pkg::MODE_APPEND, $urandom());
		add_request(vtsrs_pkg::MODE_APPEND, 1);
		add_request(vtsrs_pkg::MODE_SORT_DOWN, 0);
		add_request(vtsrs_pkg::MODE_LIST, 0);
		// Random requests, weighted toward appends so the table fills and drains.
		for (int n = 0; n < 250; n++) begin
			int r;
			r = $urandom_range(0, 19);
			if (r < 7) add_request(vtsrs_pkg::MODE_APPEND, pick_value());
			else if (r < 9) add_request(vtsrs_pkg::MODE_SEARCH, pick_value());
			else if (r < 11) add_request(vtsrs_pkg::MODE_REMOVE_ONE, pick_value());
			else if (r < 13) add_request(vtsrs_pkg::MODE_REMOVE_ALL, pick_value());
			else if (r < 15) add_request(vtsrs_pkg::MODE_LIST, $urandom());
			else if (r < 17) add_request(vtsrs_pkg::MODE_SORT_UP, $urandom());
			else if (r < 19) add_request(vtsrs_pkg::MODE_SORT_DOWN, $urandom());
			else add_request(vtsrs_pkg::MODE_NONE, $urandom());
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// A stretch with no idle cycles midway through the random part.
		while (pending_requests.size() >= 150) @(negedge clk);
		quiet_stretch = 1'b1;
		while (pending_requests.size() >= 100) @(negedge clk);
		quiet_stretch = 1'b0;
		// Wait until every request is taken and all of its results are seen.
		while (pending_requests.size() != 0 || start || busy
				|| expected_results.size() != 0)
			@(negedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// File: files.f
design/vtsrs_pkg.sv
design/vtsrs_ram.sv
design/value_table_search_remove_sort_unit.sv
test/value_table_search_remove_sort_unit_test.sv
